/* hdl/bsd_pkg.sv */
// Package for the BER SEQUENCE deframer: widths, framing constants and sideband bit positions.
// Used by the deframer top level and by its port checker; depends on nothing else.
package bsd_pkg;

	// Widths of the stream payloads and of the frame size register.
	localparam int DATA_W   = 8;
	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 4;
	localparam int SIZE_W   = 17;
	localparam int ACC_W    = 32;

	// Size of the receive buffer; the frame limit never exceeds it.
	localparam logic [SIZE_W-1:0] BUFFER_BYTES = 17'd65536;
	localparam logic [SIZE_W-1:0] MAX_FRAME_RESET = 17'd65536;

	// Framing bytes of a BER SEQUENCE header.
	localparam logic [DATA_W-1:0] TAG_SEQUENCE = 8'h30;
	localparam logic [DATA_W-1:0] LEN_LONG_MIN = 8'h81;
	localparam logic [DATA_W-1:0] LEN_LONG_MAX = 8'h84;
	localparam logic [DATA_W-1:0] LEN_SHORT_LIMIT = 8'h80;

	// Bit positions of the result flags in the output tuser.
	localparam int U_HAS_PAYLOAD = 0;
	localparam int U_EMPTY       = 1;
	localparam int U_ABORTED     = 2;
	localparam int U_FRAME_ERR   = 3;

	// One result item as it leaves the parser.
	typedef struct packed {
		logic [DATA_W-1:0] payload_byte;
		logic              has_payload;
		logic              last_of_message;
		logic              empty_message;
		logic              aborted;
		logic              framing_error;
	} result_t;

endpackage

/* hdl/ber_sequence_deframer.sv */
// BER SEQUENCE deframer: one input register, a single-pass header and payload parser, one result register.
// Depends on bsd_pkg. An accepted byte passes through the input register and then the result register to the output.
// Throughput is one byte per cycle while the output is not stalled; the parser next state is combinational.
// An input byte is taken while a finished result still waits, held in the input register.
// Reset (arst_n low) clears the parser to wait for a tag byte and sets the frame limit to 65536.
// There is no clearing pass: the block takes items as soon as reset is released.
module ber_sequence_deframer
	import bsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel: max_frame_bytes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [SIZE_W-1:0]     cfg_data,
	// Received bytes.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,   // [7:0] data_byte
	input  logic                  s_axis_tlast,   // chunk_end
	input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [0] after_gap
	// Framed results.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [DATA_W-1:0]     m_axis_tdata,   // [7:0] payload_byte
	output logic                  m_axis_tlast,   // last_of_message
	output logic [OUT_USER_W-1:0] m_axis_tuser    // [0] has_payload, [1] empty_message,
	                                              // [2] aborted, [3] framing_error
);

	// Parser phases.
	localparam logic [2:0] PH_TAG  = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_LEXT = 3'd2;
	localparam logic [2:0] PH_PAY  = 3'd3;
	localparam logic [2:0] PH_DROP = 3'd4;

	logic [SIZE_W-1:0] max_frame_q;
	logic [SIZE_W-1:0] limit;

	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              cend_s1;
	logic              gap_s1;
	logic              advance;

	logic [2:0]        phase_q;
	logic [ACC_W-1:0]  acc_q;
	logic [2:0]        len_left_q;
	logic [2:0]        hdr_seen_q;
	logic [SIZE_W-1:0] pay_left_q;
	logic              pay_started_q;

	logic [2:0]        phase_d;
	logic [ACC_W-1:0]  acc_d;
	logic [2:0]        len_left_d;
	logic [2:0]        hdr_seen_d;
	logic [SIZE_W-1:0] pay_left_d;
	logic              pay_started_d;

	result_t           res_d;
	logic              produce;
	logic              err;
	logic              abort_flag;
	logic              finish;
	logic [SIZE_W:0]   total;
	logic              too_big;

	logic              out_valid_q;
	result_t           out_q;

	// Configuration register; always ready. Writes must come only while idle; the block itself does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_frame_q <= cfg_data;
		end
	end

	assign limit = (max_frame_q > BUFFER_BYTES) ? BUFFER_BYTES : max_frame_q;

	// The input register advances whenever the result register is free or is being emptied.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			cend_s1 <= s_axis_tlast;
			gap_s1  <= s_axis_tuser[0];
		end
	end

	// Next parser state and the result for the byte in the input register.
	always_comb begin
		phase_d       = phase_q;
		acc_d         = acc_q;
		len_left_d    = len_left_q;
		hdr_seen_d    = hdr_seen_q;
		pay_left_d    = pay_left_q;
		pay_started_d = pay_started_q;
		res_d         = '0;
		produce       = 1'b0;
		err           = 1'b0;
		abort_flag    = 1'b0;
		finish        = 1'b0;
		total         = '0;
		too_big       = 1'b0;

		// A gap drops any partial frame; a frame with delivered bytes reports an abort.
		if (gap_s1) begin
			abort_flag    = (phase_q == PH_PAY) && pay_started_q;
			phase_d       = PH_TAG;
			pay_started_d = 1'b0;
			pay_left_d    = '0;
		end

		unique case (phase_d)
			PH_TAG: begin
				if (byte_s1 == TAG_SEQUENCE) begin
					hdr_seen_d = 3'd1;
					acc_d      = '0;
					len_left_d = '0;
					phase_d    = PH_LEN;
				end else begin
					err = 1'b1;
				end
			end
			PH_LEN: begin
				hdr_seen_d = 3'd2;
				if (byte_s1 < LEN_SHORT_LIMIT) begin
					acc_d  = {{(ACC_W-DATA_W){1'b0}}, byte_s1};
					finish = 1'b1;
				end else if (byte_s1 >= LEN_LONG_MIN && byte_s1 <= LEN_LONG_MAX) begin
					len_left_d = byte_s1[2:0];
					acc_d      = '0;
					phase_d    = PH_LEXT;
				end else begin
					err = 1'b1;
				end
			end
			PH_LEXT: begin
				acc_d      = {acc_q[ACC_W-DATA_W-1:0], byte_s1};
				hdr_seen_d = hdr_seen_q + 3'd1;
				if (len_left_q != 3'd0) begin
					len_left_d = len_left_q - 3'd1;
				end
				if (len_left_d == 3'd0) begin
					finish = 1'b1;
				end
			end
			PH_PAY: begin
				res_d.payload_byte = byte_s1;
				res_d.has_payload  = 1'b1;
				pay_started_d      = 1'b1;
				if (pay_left_q != '0) begin
					pay_left_d = pay_left_q - SIZE_W'(1);
				end
				if (pay_left_d == '0) begin
					res_d.last_of_message = 1'b1;
					phase_d               = PH_TAG;
					pay_started_d         = 1'b0;
				end
				produce = 1'b1;
			end
			default: begin
				// Discarding the rest of a chunk after an error.
				if (cend_s1) begin
					phase_d = PH_TAG;
				end
			end
		endcase

		// Header complete: size check, then an empty message or the start of the payload.
		if (finish) begin
			total   = {1'b0, acc_d[SIZE_W-1:0]} + {{(SIZE_W-2){1'b0}}, hdr_seen_d};
			too_big = (|acc_d[ACC_W-1:SIZE_W]) || (total > {1'b0, limit});
			if (too_big) begin
				err = 1'b1;
			end else if (acc_d == '0) begin
				phase_d               = PH_TAG;
				res_d.last_of_message = 1'b1;
				res_d.empty_message   = 1'b1;
				produce               = 1'b1;
			end else begin
				pay_left_d    = acc_d[SIZE_W-1:0];
				pay_started_d = 1'b0;
				phase_d       = PH_PAY;
			end
		end

		// An error replaces any payload or empty-message result and discards to the end of the chunk.
		if (err) begin
			res_d               = '0;
			res_d.framing_error = 1'b1;
			produce             = 1'b1;
			phase_d             = cend_s1 ? PH_TAG : PH_DROP;
			pay_started_d       = 1'b0;
			pay_left_d          = '0;
			len_left_d          = '0;
		end

		if (abort_flag) begin
			res_d.aborted = 1'b1;
			produce       = 1'b1;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			acc_q         <= '0;
			len_left_q    <= '0;
			hdr_seen_q    <= '0;
			pay_left_q    <= '0;
			pay_started_q <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			acc_q         <= acc_d;
			len_left_q    <= len_left_d;
			hdr_seen_q    <= hdr_seen_d;
			pay_left_q    <= pay_left_d;
			pay_started_q <= pay_started_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q.payload_byte;
	assign m_axis_tlast  = out_q.last_of_message;
	assign m_axis_tuser  = {out_q.framing_error, out_q.aborted,
	                        out_q.empty_message, out_q.has_payload};

endmodule

/* hdl/bsd_checker.sv */
// Port checker for the BER SEQUENCE deframer, attached to the top level by a bind statement.
// Depends on bsd_pkg for widths and the positions of the result flags in tuser.
module bsd_checker
	import bsd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [DATA_W-1:0]     m_axis_tdata,
	input logic                  m_axis_tlast,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	// A stalled result holds its data and flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// A framing error carries no content byte and ends no message.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[U_FRAME_ERR] |->
			m_axis_tdata == '0 && !m_axis_tlast &&
			!m_axis_tuser[U_HAS_PAYLOAD] && !m_axis_tuser[U_EMPTY])
		else $error("framing error result carries message data");

	// An empty message is the end of a message without a content byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[U_EMPTY] |->
			m_axis_tlast && !m_axis_tuser[U_HAS_PAYLOAD] && m_axis_tdata == '0)
		else $error("empty message result malformed");

	// The data byte is zero unless a content byte is carried.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[U_HAS_PAYLOAD] |-> m_axis_tdata == '0)
		else $error("data byte set without payload");

endmodule

bind ber_sequence_deframer bsd_checker u_bsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

/* dv/ber_deframe_checker.sv */
`timescale 1ns / 1ps
// Result checker for the BER SEQUENCE deframer: watches the byte, result and limit channels.
// It predicts every result item from the accepted bytes and compares them in order.
// Depends on bsd_pkg for widths, framing bytes and the result layout.
module ber_deframe_checker
	import bsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [SIZE_W-1:0]     cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [DATA_W-1:0]     s_axis_tdata,
	input  logic                  s_axis_tlast,
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [DATA_W-1:0]     m_axis_tdata,
	input  logic                  m_axis_tlast,
	input  logic [OUT_USER_W-1:0] m_axis_tuser,
	output int                    fail_count,
	output int                    pending_count
);

	typedef enum logic [2:0] {
		AWAIT_TAG,
		AWAIT_LEN,
		LEN_BYTES,
		PAYLOAD,
		DISCARD
	} parse_phase_t;

	// Shadow copy of the parser state and of the frame limit register.
	parse_phase_t      parse_phase;
	logic [ACC_W-1:0]  declared_len;
	logic [2:0]        len_bytes_left;
	logic [2:0]        header_len;
	logic [ACC_W-1:0]  payload_left;
	logic              payload_begun;
	logic [SIZE_W-1:0] frame_cap;

	result_t expected_results[$];
	int      failures = 0;

	task automatic log_failure(input string what, input result_t want, input result_t seen);
		failures++;
		if (failures <= 10) begin
			$display("%0t: %s: expected byte %02h has %b last %b empty %b abort %b err %b",
				$time, what, want.payload_byte, want.has_payload, want.last_of_message,
				want.empty_message, want.aborted, want.framing_error);
			$display("%0t:    got      byte %02h has %b last %b empty %b abort %b err %b",
				$time, seen.payload_byte, seen.has_payload, seen.last_of_message,
				seen.empty_message, seen.aborted, seen.framing_error);
		end
	endtask

	// Advance the shadow parser by one received byte and queue the result it causes.
	task automatic deframe_byte(input logic [DATA_W-1:0] b, input logic cend, input logic gap);
		result_t     res;
		logic        emit;
		logic        bad;
		logic        dropped;
		logic        header_done;
		logic [33:0] frame_total;
		logic [SIZE_W-1:0] cap;

		res = '0;
		emit = 1'b0;
		bad = 1'b0;
		dropped = 1'b0;
		header_done = 1'b0;
		cap = (frame_cap > BUFFER_BYTES) ? BUFFER_BYTES : frame_cap;

		// A gap throws away any partial frame; only a started payload is reported.
		if (gap) begin
			if (parse_phase == PAYLOAD && payload_begun)
				dropped = 1'b1;
			parse_phase = AWAIT_TAG;
			payload_begun = 1'b0;
			payload_left = '0;
		end

		case (parse_phase)
			AWAIT_TAG: begin
				if (b == TAG_SEQUENCE) begin
					header_len = 3'd1;
					declared_len = '0;
					len_bytes_left = '0;
					parse_phase = AWAIT_LEN;
				end else begin
					bad = 1'b1;
				end
			end
			AWAIT_LEN: begin
				header_len = 3'd2;
				if (b < LEN_SHORT_LIMIT) begin
					declared_len = ACC_W'(b);
					header_done = 1'b1;
				end else if (b >= LEN_LONG_MIN && b <= LEN_LONG_MAX) begin
					len_bytes_left = 3'(b - LEN_SHORT_LIMIT);
					declared_len = '0;
					parse_phase = LEN_BYTES;
				end else begin
					bad = 1'b1;
				end
			end
			LEN_BYTES: begin
				declared_len = {declared_len[ACC_W-DATA_W-1:0], b};
				header_len = header_len + 3'd1;
				if (len_bytes_left != 0)
					len_bytes_left = len_bytes_left - 3'd1;
				if (len_bytes_left == 0)
					header_done = 1'b1;
			end
			PAYLOAD: begin
				res.payload_byte = b;
				res.has_payload = 1'b1;
				payload_begun = 1'b1;
				emit = 1'b1;
				if (payload_left != 0)
					payload_left = payload_left - 1;
				if (payload_left == 0) begin
					res.last_of_message = 1'b1;
					parse_phase = AWAIT_TAG;
					payload_begun = 1'b0;
				end
			end
			default: begin
				if (cend)
					parse_phase = AWAIT_TAG;
			end
		endcase

		// Header complete: check the frame size, then start the payload or close an empty one.
		if (header_done) begin
			frame_total = 34'(header_len) + 34'(declared_len);
			if (frame_total > 34'(cap)) begin
				bad = 1'b1;
			end else if (declared_len == 0) begin
				parse_phase = AWAIT_TAG;
				res.last_of_message = 1'b1;
				res.empty_message = 1'b1;
				emit = 1'b1;
			end else begin
				payload_left = declared_len;
				payload_begun = 1'b0;
				parse_phase = PAYLOAD;
			end
		end

		// A framing error replaces any payload or empty-message result and discards the rest of the chunk.
		if (bad) begin
			res = '0;
			res.framing_error = 1'b1;
			emit = 1'b1;
			parse_phase = cend ? AWAIT_TAG : DISCARD;
			payload_begun = 1'b0;
			payload_left = '0;
			len_bytes_left = '0;
		end

		if (dropped) begin
			res.aborted = 1'b1;
			emit = 1'b1;
		end

		if (emit)
			expected_results.push_back(res);
	endtask

	// Compare results first, since a result never comes from the byte taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			parse_phase = AWAIT_TAG;
			declared_len = '0;
			len_bytes_left = '0;
			header_len = '0;
			payload_left = '0;
			payload_begun = 1'b0;
			frame_cap = MAX_FRAME_RESET;
			expected_results.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.payload_byte = m_axis_tdata;
				seen.has_payload = m_axis_tuser[U_HAS_PAYLOAD];
				seen.last_of_message = m_axis_tlast;
				seen.empty_message = m_axis_tuser[U_EMPTY];
				seen.aborted = m_axis_tuser[U_ABORTED];
				seen.framing_error = m_axis_tuser[U_FRAME_ERR];
				if (expected_results.size() == 0) begin
					log_failure("result with none expected", '0, seen);
				end else begin
					want = expected_results.pop_front();
					if (seen.payload_byte !== want.payload_byte ||
						seen.has_payload !== want.has_payload ||
						seen.last_of_message !== want.last_of_message ||
						seen.empty_message !== want.empty_message ||
						seen.aborted !== want.aborted ||
						seen.framing_error !== want.framing_error)
						log_failure("result mismatch", want, seen);
				end
			end
			if (cfg_valid && cfg_ready)
				frame_cap = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser[0]);
			fail_count <= failures;
			pending_count <= expected_results.size();
		end
	end

endmodule

/* dv/ber_sequence_deframer_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the BER SEQUENCE deframer: clock, reset, byte stimulus, frame limit writes.
// Depends on bsd_pkg, the deframer RTL and ber_deframe_checker, which predicts and compares.
module ber_sequence_deframer_tb;
	import bsd_pkg::*;

	localparam int SEGMENTS     = 7;
	localparam int SEG_ITEMS    = 230;
	localparam int HOLD_AT      = 800;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [SIZE_W-1:0]     cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DATA_W-1:0]     s_axis_tdata = '0;    // [7:0] data_byte
	logic                  s_axis_tlast = 1'b0;  // chunk_end
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;    // [0] after_gap
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DATA_W-1:0]     m_axis_tdata;         // [7:0] payload_byte
	logic                  m_axis_tlast;         // last_of_message
	logic [OUT_USER_W-1:0] m_axis_tuser;         // [0] has_payload, [1] empty_message,
	                                             // [2] aborted, [3] framing_error

	int fail_count;
	int pending_count;
	int tx_idle_pct = 17;
	int rx_idle_pct = 48;
	int sent_count = 0;
	int cycle_count = 0;
	int limit_now = int'(MAX_FRAME_RESET);
	bit gap_pending = 1'b0;
	bit hold_done = 1'b0;

	ber_sequence_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	ber_deframe_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL ber_sequence_deframer");
			$finish;
		end
	end

	// Result side: random stalls, and once a long hold-off so the block backs up.
	initial begin
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offer one byte, with random idle cycles first, and wait until it is taken.
	task automatic put_byte(input logic [DATA_W-1:0] b, input logic cend, input logic gap);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= cend;
		s_axis_tuser <= gap;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_count++;
	endtask

	// Stop offering and wait until every expected result is out and the pipe is empty.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_frame_limit(input logic [SIZE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		limit_now = int'(value);
	endtask

	// One random message: mostly well-formed frames, plus truncated, bad and oversize ones.
	task automatic send_message();
		logic [DATA_W-1:0] msg[$];
		int     kind;
		int     nlen;
		int     need;
		int     hdr;
		int     cap;
		int     keep;
		int     i;
		longint decl;
		bit     gap_first;
		bit     ends_chunk;
		bit     noise;
		bit     cend;
		bit     gap;

		kind = $urandom_range(99);
		gap_first = gap_pending;
		gap_pending = 1'b0;
		noise = 1'b0;
		ends_chunk = 1'b1;
		cap = (limit_now > int'(BUFFER_BYTES)) ? int'(BUFFER_BYTES) : limit_now;

		if (kind < 82) begin
			nlen = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0;
			case ($urandom_range(7))
				0: decl = 0;
				1, 2: begin
					// Sizes right at the limit and one past it.
					if (nlen == 0 && cap > 120)
						nlen = 3;
					decl = longint'(cap - 2 - nlen);
					if (kind % 2 == 1)
						decl++;
					if (decl < 0)
						decl = 0;
				end
				3: decl = longint'($urandom);
				default: decl = $urandom_range(1, 24);
			endcase
			need = (decl < 256) ? 1 : (decl < 65536) ? 2 : (decl < 64'd16777216) ? 3 : 4;
			if ((nlen == 0 && decl > 127) || (nlen > 0 && nlen < need))
				nlen = need;
			hdr = 2 + nlen;

			msg.push_back(TAG_SEQUENCE);
			if (nlen == 0) begin
				msg.push_back(DATA_W'(decl));
			end else begin
				msg.push_back(LEN_SHORT_LIMIT + DATA_W'(nlen));
				for (i = nlen - 1; i >= 0; i--)
					msg.push_back(DATA_W'(decl >> (8 * i)));
			end

			if (longint'(hdr) + decl > longint'(cap)) begin
				repeat ($urandom_range(3)) msg.push_back(DATA_W'($urandom_range(255)));
			end else if (kind >= 70 || decl > 64) begin
				// Cut short and followed by a gap.
				if (decl == 0 || $urandom_range(3) == 0) begin
					keep = $urandom_range(1, hdr - 1);
					while (msg.size() > keep)
						void'(msg.pop_back());
				end else begin
					repeat ($urandom_range(1, (decl > 8) ? 8 : int'(decl)))
						msg.push_back(DATA_W'($urandom_range(255)));
				end
				gap_pending = 1'b1;
				ends_chunk = $urandom_range(1);
			end else begin
				repeat (int'(decl)) msg.push_back(DATA_W'($urandom_range(255)));
				ends_chunk = $urandom_range(1);
			end
		end else if (kind < 90) begin
			// Wrong tag, then the rest of the chunk.
			do
				msg.push_back(DATA_W'($urandom_range(255)));
			while (msg[0] == TAG_SEQUENCE && msg.size() == 1 && (msg.pop_back() >= 0));
			repeat ($urandom_range(4)) msg.push_back(DATA_W'($urandom_range(255)));
		end else if (kind < 96) begin
			// Indefinite or unsupported length form.
			msg.push_back(TAG_SEQUENCE);
			if ($urandom_range(1))
				msg.push_back(LEN_SHORT_LIMIT);
			else
				msg.push_back(DATA_W'($urandom_range(int'(LEN_LONG_MAX) + 1, 255)));
			repeat ($urandom_range(3)) msg.push_back(DATA_W'($urandom_range(255)));
		end else begin
			noise = 1'b1;
			repeat ($urandom_range(1, 6)) msg.push_back(DATA_W'($urandom_range(255)));
		end

		for (i = 0; i < msg.size(); i++) begin
			if (noise) begin
				cend = $urandom_range(1);
				gap = ($urandom_range(3) == 0);
			end else begin
				cend = (i == msg.size() - 1 && ends_chunk) || ($urandom_range(29) == 0);
				gap = (i == 0 && gap_first) || ($urandom_range(99) == 0);
			end
			put_byte(msg[i], cend, gap);
		end
	endtask

	// Stimulus and verdict.
	initial begin
		int seg;
		int seg_start;
		logic [SIZE_W-1:0] seg_limit;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset limit.
		put_byte(TAG_SEQUENCE, 1'b0, 1'b0);          // empty message, short form
		put_byte(8'h00, 1'b0, 1'b0);
		put_byte(TAG_SEQUENCE, 1'b0, 1'b0);          // two length bytes, chunk end on the last payload byte
		put_byte(LEN_LONG_MIN + 8'd1, 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b0);
		put_byte(8'h02, 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b0);
		put_byte(8'hFF, 1'b1, 1'b0);
		put_byte(TAG_SEQUENCE, 1'b0, 1'b0);          // indefinite length on a chunk end
		put_byte(LEN_SHORT_LIMIT, 1'b1, 1'b0);
		put_byte(TAG_SEQUENCE, 1'b0, 1'b0);          // bad length form, rest of chunk dropped
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'h77, 1'b1, 1'b0);
		put_byte(TAG_SEQUENCE, 1'b0, 1'b0);          // largest four-byte length: oversize
		put_byte(LEN_LONG_MAX, 1'b0, 1'b0);
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(TAG_SEQUENCE, 1'b0, 1'b1);          // gap ends discarding, new frame
		put_byte(8'h03, 1'b0, 1'b0);
		put_byte(8'h01, 1'b0, 1'b0);
		put_byte(8'h00, 1'b1, 1'b1);                 // gap in payload on a bad tag
		put_byte(TAG_SEQUENCE, 1'b0, 1'b0);          // partial header dropped by a gap
		put_byte(LEN_LONG_MIN, 1'b0, 1'b0);
		put_byte(TAG_SEQUENCE, 1'b0, 1'b1);
		put_byte(8'h00, 1'b0, 1'b0);

		// Random segments, each at its own frame limit value, with one of three idling patterns.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: seg_limit = 17'd40;
				1: seg_limit = 17'd2;
				2: seg_limit = 17'd0;
				3: seg_limit = 17'd300;
				4: seg_limit = 17'd1;
				5: seg_limit = MAX_FRAME_RESET;
				default: seg_limit = '1;
			endcase
			wait_drained();
			write_frame_limit(seg_limit);
			if (seg < 2) begin
				tx_idle_pct = 17;
				rx_idle_pct = 48;
			end else if (seg < 5) begin
				tx_idle_pct = 48;
				rx_idle_pct = 17;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			seg_start = sent_count;
			while (sent_count - seg_start < SEG_ITEMS)
				send_message();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("PASS ber_sequence_deframer");
		else
			$display("FAIL ber_sequence_deframer");
		$finish;
	end

endmodule

/* files.f */
hdl/bsd_pkg.sv
hdl/ber_sequence_deframer.sv
hdl/bsd_checker.sv
dv/ber_deframe_checker.sv
dv/ber_sequence_deframer_tb.sv
